>>> rtl/core/owsl_pkg.sv
`default_nettype none

package owsl_pkg;

    localparam int VEL_W      = 16;
    localparam int SPEED_W    = 24;
    localparam int CFG_DATA_W = 24;
    localparam int CFG_IDX_W  = 2;

    localparam logic [CFG_IDX_W-1:0] REG_WHEELBASE    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_RADIUS       = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ACCEL_LIMIT  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_TIME_STEP    = 2'd3;

    localparam logic [15:0] WHEELBASE_RST    = 16'd369;
    localparam logic [15:0] RADIUS_RST       = 16'd123;
    localparam logic [23:0] ACCEL_LIMIT_RST  = 24'd12800;
    localparam logic [15:0] TIME_STEP_RST    = 16'd655;

    // sqrt(3) and 1/sqrt(2) at 2^-16
    localparam logic signed [24:0] SQRT3_Q16     = 25'sd113512;
    localparam logic signed [24:0] INV_SQRT2_Q16 = 25'sd46341;

    localparam int MAG_W    = 38;
    localparam int DVS_W    = 21;
    localparam int QUO_W    = SPEED_W;
    localparam int DIV_ITER = QUO_W / 2;
    localparam int DCNT_W   = $clog2(DIV_ITER + 1);

    typedef struct packed {
        logic             start;
        logic [MAG_W-1:0] mag;
        logic [DVS_W-1:0] dvs;
    } div_req_t;

    typedef struct packed {
        logic             done;
        logic             ovf;
        logic [QUO_W-1:0] quo;
    } div_rsp_t;

endpackage

`default_nettype wire

>>> rtl/core/owsl_if.sv
`default_nettype none

interface owsl_cmd_if import owsl_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic signed [VEL_W-1:0] vel_x;
    logic signed [VEL_W-1:0] vel_y;
    logic signed [VEL_W-1:0] turn_rate;

    modport source (output valid, vel_x, vel_y, turn_rate, input ready);
    modport sink   (input valid, vel_x, vel_y, turn_rate, output ready);
endinterface

interface owsl_speed_if import owsl_pkg::*; ();
    logic                      valid;
    logic                      ready;
    logic signed [SPEED_W-1:0] right_rear_speed;
    logic signed [SPEED_W-1:0] right_front_speed;
    logic signed [SPEED_W-1:0] left_rear_speed;
    logic signed [SPEED_W-1:0] left_front_speed;

    modport source (output valid, right_rear_speed, right_front_speed,
                    left_rear_speed, left_front_speed, input ready);
    modport sink   (input valid, right_rear_speed, right_front_speed,
                    left_rear_speed, left_front_speed, output ready);
endinterface

interface owsl_cfg_if import owsl_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

>>> rtl/core/owsl_div.sv
`default_nettype none

module owsl_div
    import owsl_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  div_req_t req,
    output div_rsp_t rsp
);

    logic [QUO_W-1:0]  q_reg, q_next;
    logic [DVS_W-1:0]  p_reg, p_next;
    logic [DVS_W-1:0]  d_reg, d_next;
    logic              ovf_reg, ovf_next;
    logic [DCNT_W-1:0] cnt_reg, cnt_next;
    logic              busy_reg, busy_next;
    logic              done_reg, done_next;

    logic [QUO_W-1:0]  q_it;
    logic [DVS_W-1:0]  p_it;
    logic [DVS_W:0]    sh;

    // two restoring steps a cycle
    always_comb
    begin
        q_it = q_reg;
        p_it = p_reg;
        sh   = '0;
        for (int k = 0; k < 2; k++)
        begin
            sh   = {p_it, q_it[QUO_W-1]};
            q_it = {q_it[QUO_W-2:0], 1'b0};
            if (sh >= {1'b0, d_reg})
            begin
                sh      = sh - {1'b0, d_reg};
                q_it[0] = 1'b1;
            end
            p_it = sh[DVS_W-1:0];
        end
    end

    always_comb
    begin
        q_next    = q_reg;
        p_next    = p_reg;
        d_next    = d_reg;
        ovf_next  = ovf_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (req.start)
        begin
            ovf_next  = ({{(DVS_W + QUO_W - MAG_W){1'b0}}, req.mag}
                         >= {req.dvs, {QUO_W{1'b0}}});
            p_next    = DVS_W'(req.mag[MAG_W-1:QUO_W]);
            q_next    = req.mag[QUO_W-1:0];
            d_next    = req.dvs;
            cnt_next  = DCNT_W'(DIV_ITER);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            q_next   = q_it;
            p_next   = p_it;
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == DCNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg   <= q_next;
        p_reg   <= p_next;
        d_reg   <= d_next;
        ovf_reg <= ovf_next;
    end

    assign rsp.done = done_reg;
    assign rsp.ovf  = ovf_reg;
    assign rsp.quo  = q_reg;

endmodule

`default_nettype wire

>>> rtl/core/omni_wheel_speed_with_slew_limit.sv
`default_nettype none

// Omni-wheel mixer with per-wheel slew limit. A command (vel_x, vel_y, turn_rate, Q7.8)
// is taken only while cmd.ready is high; the four limited wheel speeds (Q15.8, saturating)
// then appear together on one speed transfer. One shared multiplier forms the five products,
// then each wheel in turn runs through a radix-4 divider by 32 times the radius (twelve
// iterations) and a slew step. The finished result sits in an output register, and a new
// command is taken as soon as that register is loaded. Configuration writes are always
// ready and take effect at once; the user must write only between commands for a write to
// apply to the next command, as the block does not enforce it. A zero radius acts as 1.
module omni_wheel_speed_with_slew_limit
    import owsl_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    owsl_cmd_if.sink            cmd,
    owsl_cfg_if.sink            cfg,
    owsl_speed_if.source        spd
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_MUL   = 3'd1;
    localparam logic [2:0] S_SUM   = 3'd2;
    localparam logic [2:0] S_START = 3'd3;
    localparam logic [2:0] S_DIV   = 3'd4;
    localparam logic [2:0] S_SLEW  = 3'd5;
    localparam logic [2:0] S_FIN   = 3'd6;

    localparam logic [2:0] MUL_TURN  = 3'd0;
    localparam logic [2:0] MUL_SQRT3 = 3'd1;
    localparam logic [2:0] MUL_SUM   = 3'd2;
    localparam logic [2:0] MUL_DIFF  = 3'd3;
    localparam logic [2:0] MUL_STEP  = 3'd4;

    localparam int M_W = MAG_W + 1;

    logic [2:0] state_reg, state_next;
    logic [2:0] cnt_reg, cnt_next;
    logic [1:0] wheel_reg, wheel_next;

    logic [15:0] wheelbase_reg;
    logic [15:0] radius_reg;
    logic [23:0] accel_reg;
    logic [15:0] tstep_reg;

    logic signed [VEL_W-1:0] vx_reg, vy_reg, w_reg;

    logic signed [32:0]        lw_reg;
    logic signed [33:0]        s3_reg, pa_reg, pb_reg;
    logic [SPEED_W-1:0]        step_reg;
    logic signed [M_W-1:0]     m_reg, m_next;
    logic                      neg_reg;

    logic signed [SPEED_W-1:0] last_reg [4];
    logic signed [SPEED_W-1:0] out_reg [4];
    logic                      out_valid_reg, out_valid_next;

    logic signed [24:0] mul_a;
    logic signed [17:0] mul_b;
    logic signed [42:0] mul_p;

    logic signed [M_W-1:0] turn_t, vy_t, s3_t, pa_t, pb_t, m_abs;

    div_req_t div_req;
    div_rsp_t div_rsp;

    logic signed [SPEED_W-1:0] target, prev, slew_v;
    logic signed [SPEED_W:0]   diff;
    logic [SPEED_W:0]          diff_mag;
    logic signed [SPEED_W+1:0] moved;
    logic signed [SPEED_W+1:0] chg;
    logic [SPEED_W+1:0]        chg_mag;
    logic                      cmd_xfer, load_out;

    function automatic logic signed [SPEED_W-1:0] sat_speed(input logic signed [SPEED_W+1:0] v);
        logic signed [SPEED_W+1:0] hi;
        logic signed [SPEED_W+1:0] lo;
        hi = (SPEED_W + 2)'(signed'({1'b0, {(SPEED_W-1){1'b1}}}));
        lo = ~hi;
        if (v > hi)
            sat_speed = hi[SPEED_W-1:0];
        else if (v < lo)
            sat_speed = lo[SPEED_W-1:0];
        else
            sat_speed = v[SPEED_W-1:0];
    endfunction

    assign cmd_xfer  = cmd.valid && cmd.ready;
    assign cmd.ready = (state_reg == S_IDLE);
    assign cfg.ready = 1'b1;

    // shared multiplier
    always_comb
    begin
        case (cnt_reg)
            MUL_TURN:
            begin
                mul_a = 25'(signed'({1'b0, wheelbase_reg}));
                mul_b = 18'(w_reg);
            end
            MUL_SQRT3:
            begin
                mul_a = SQRT3_Q16;
                mul_b = 18'(vx_reg);
            end
            MUL_SUM:
            begin
                mul_a = INV_SQRT2_Q16;
                mul_b = 18'(vx_reg) + 18'(vy_reg);
            end
            MUL_DIFF:
            begin
                mul_a = INV_SQRT2_Q16;
                mul_b = 18'(vx_reg) - 18'(vy_reg);
            end
            MUL_STEP:
            begin
                mul_a = 25'(signed'({1'b0, accel_reg}));
                mul_b = 18'(signed'({2'b00, tstep_reg}));
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p = mul_a * mul_b;

    // mixer numerator at 2^-(F+17)
    assign turn_t = M_W'(lw_reg) <<< 5;
    assign vy_t   = M_W'(vy_reg) <<< 16;
    assign s3_t   = M_W'(s3_reg);
    assign pa_t   = M_W'(pa_reg) <<< 1;
    assign pb_t   = M_W'(pb_reg) <<< 1;

    always_comb
    begin
        case (wheel_reg)
            2'd0:    m_next = turn_t + vy_t - s3_t;
            2'd1:    m_next = turn_t - pa_t;
            2'd2:    m_next = turn_t + pb_t;
            default: m_next = turn_t + vy_t + s3_t;
        endcase
    end

    assign m_abs = m_reg[M_W-1] ? -m_reg : m_reg;

    always_comb
    begin
        div_req.start = (state_reg == S_START);
        div_req.mag   = m_abs[MAG_W-1:0];
        div_req.dvs   = {((radius_reg == 16'd0) ? 16'd1 : radius_reg), 5'b0};
    end

    owsl_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    // saturate the quotient, then slew limit
    always_comb
    begin
        if (!neg_reg)
        begin
            if (div_rsp.ovf || div_rsp.quo[QUO_W-1])
                target = {1'b0, {(SPEED_W-1){1'b1}}};
            else
                target = div_rsp.quo;
        end
        else
        begin
            if (div_rsp.ovf || (div_rsp.quo > {1'b1, {(QUO_W-1){1'b0}}}))
                target = {1'b1, {(SPEED_W-1){1'b0}}};
            else
                target = -div_rsp.quo;
        end
        prev     = last_reg[wheel_reg];
        diff     = (SPEED_W + 1)'(target) - (SPEED_W + 1)'(prev);
        diff_mag = diff[SPEED_W] ? -diff : diff;
        if (diff_mag > {1'b0, step_reg})
        begin
            if (diff[SPEED_W])
                moved = (SPEED_W + 2)'(prev) - (SPEED_W + 2)'(signed'({2'b00, step_reg}));
            else
                moved = (SPEED_W + 2)'(prev) + (SPEED_W + 2)'(signed'({2'b00, step_reg}));
            slew_v = sat_speed(moved);
        end
        else
        begin
            moved  = '0;
            slew_v = target;
        end
        chg     = (SPEED_W + 2)'(slew_v) - (SPEED_W + 2)'(prev);
        chg_mag = chg[SPEED_W+1] ? -chg : chg;
    end

    assign load_out = (state_reg == S_FIN) && (!out_valid_reg || spd.ready);

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        wheel_next = wheel_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (cmd_xfer)
                begin
                    state_next = S_MUL;
                    cnt_next   = MUL_TURN;
                end
            end
            S_MUL:
            begin
                cnt_next = cnt_reg + 3'd1;
                if (cnt_reg == MUL_STEP)
                begin
                    state_next = S_SUM;
                    wheel_next = 2'd0;
                end
            end
            S_SUM:   state_next = S_START;
            S_START: state_next = S_DIV;
            S_DIV:
            begin
                if (div_rsp.done)
                    state_next = S_SLEW;
            end
            S_SLEW:
            begin
                wheel_next = wheel_reg + 2'd1;
                state_next = (wheel_reg == 2'd3) ? S_FIN : S_SUM;
            end
            S_FIN:
            begin
                if (load_out)
                    state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (spd.valid && spd.ready)
            out_valid_next = 1'b0;
        if (load_out)
            out_valid_next = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            wheel_reg     <= '0;
            out_valid_reg <= 1'b0;
            wheelbase_reg <= WHEELBASE_RST;
            radius_reg    <= RADIUS_RST;
            accel_reg     <= ACCEL_LIMIT_RST;
            tstep_reg     <= TIME_STEP_RST;
            for (int i = 0; i < 4; i++)
                last_reg[i] <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            wheel_reg     <= wheel_next;
            out_valid_reg <= out_valid_next;
            if (cfg.valid && cfg.ready)
            begin
                case (cfg.index)
                    REG_WHEELBASE:    wheelbase_reg <= cfg.data[15:0];
                    REG_RADIUS:       radius_reg    <= cfg.data[15:0];
                    REG_ACCEL_LIMIT:  accel_reg     <= cfg.data[23:0];
                    REG_TIME_STEP:    tstep_reg     <= cfg.data[15:0];
                    default:          ;
                endcase
            end
            if (state_reg == S_SLEW)
                last_reg[wheel_reg] <= slew_v;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd_xfer)
        begin
            vx_reg <= cmd.vel_x;
            vy_reg <= cmd.vel_y;
            w_reg  <= cmd.turn_rate;
        end
        if (state_reg == S_MUL)
        begin
            case (cnt_reg)
                MUL_TURN:  lw_reg   <= mul_p[32:0];
                MUL_SQRT3: s3_reg   <= mul_p[33:0];
                MUL_SUM:   pa_reg   <= mul_p[33:0];
                MUL_DIFF:  pb_reg   <= mul_p[33:0];
                MUL_STEP:  step_reg <= mul_p[39:16];
                default:   ;
            endcase
        end
        if (state_reg == S_SUM)
            m_reg <= m_next;
        if (state_reg == S_START)
            neg_reg <= m_reg[M_W-1];
        if (load_out)
        begin
            for (int i = 0; i < 4; i++)
                out_reg[i] <= last_reg[i];
        end
    end

    assign spd.valid             = out_valid_reg;
    assign spd.right_rear_speed  = out_reg[0];
    assign spd.right_front_speed = out_reg[1];
    assign spd.left_rear_speed   = out_reg[2];
    assign spd.left_front_speed  = out_reg[3];

    a_cmd_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_xfer |=> !cmd.ready)
        else $error("command taken while busy");

    a_div_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
        div_rsp.done |-> (state_reg == S_DIV))
        else $error("divider finished outside its wait state");

    a_slew_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SLEW) |-> (chg_mag <= {2'b00, step_reg}))
        else $error("speed change exceeds the allowed step");

    a_out_matches_state: assert property (@(posedge clk) disable iff (!rst_n)
        load_out |=> (spd.valid && spd.left_front_speed == last_reg[3]
                      && spd.right_rear_speed == last_reg[0]))
        else $error("output does not match stored speeds");

endmodule

`default_nettype wire

>>> tb/sv/omni_wheel_speed_with_slew_limit_chk.sv
`default_nettype none

module omni_wheel_speed_with_slew_limit_chk
    import owsl_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    owsl_cmd_if    cmd,
    owsl_cfg_if    cfg,
    owsl_speed_if  spd,
    output int     fail_count,
    output int     owed_count
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic signed [SPEED_W-1:0] right_rear;
        logic signed [SPEED_W-1:0] right_front;
        logic signed [SPEED_W-1:0] left_rear;
        logic signed [SPEED_W-1:0] left_front;
    } wheel_speeds_t;

    localparam longint SPEED_TOP = 64'sd8388607;
    localparam longint SPEED_BOT = -64'sd8388608;

    string wheel_names [4] = '{"right_rear", "right_front", "left_rear", "left_front"};

    wheel_speeds_t             owed_speeds [$];
    logic [15:0]               wheelbase_q;
    logic [15:0]               radius_q;
    logic [23:0]               accel_q;
    logic [15:0]               tstep_q;
    logic signed [SPEED_W-1:0] held_speed [4];

    function automatic longint clamp_speed(longint v);
        if (v > SPEED_TOP)
            return SPEED_TOP;
        if (v < SPEED_BOT)
            return SPEED_BOT;
        return v;
    endfunction

    function automatic longint limit_slew(longint target, longint prev, longint allow);
        longint diff;
        longint mag;
        diff = target - prev;
        mag  = (diff < 0) ? -diff : diff;
        if (mag * 65536 > allow)
        begin
            if (diff > 0)
                return clamp_speed(prev + (allow >> 16));
            return clamp_speed(prev - (allow >> 16));
        end
        return target;
    endfunction

    function automatic wheel_speeds_t mix_and_limit(logic signed [VEL_W-1:0] vx_in,
                                                    logic signed [VEL_W-1:0] vy_in,
                                                    logic signed [VEL_W-1:0] w_in);
        longint        vx;
        longint        vy;
        longint        w;
        longint        base;
        longint        rad;
        longint        dvs;
        longint        turn;
        longint        accel;
        longint        tstep;
        longint        allow;
        longint        num [4];
        longint        lim [4];
        wheel_speeds_t res;
        vx    = vx_in;
        vy    = vy_in;
        w     = w_in;
        base  = wheelbase_q;
        rad   = (radius_q == 16'd0) ? 1 : radius_q;
        dvs   = rad * 65536;
        accel = accel_q;
        tstep = tstep_q;
        allow = accel * tstep;
        turn  = base * w * 65536;
        num[0] = turn + (vy * 65536 - longint'(SQRT3_Q16) * vx) * 2048;
        num[1] = turn - (vx + vy) * longint'(INV_SQRT2_Q16) * 4096;
        num[2] = turn + (vx - vy) * longint'(INV_SQRT2_Q16) * 4096;
        num[3] = turn + (vy * 65536 + longint'(SQRT3_Q16) * vx) * 2048;
        for (int i = 0; i < 4; i++)
            lim[i] = limit_slew(clamp_speed(num[i] / dvs), held_speed[i], allow);
        res.right_rear  = lim[0][SPEED_W-1:0];
        res.right_front = lim[1][SPEED_W-1:0];
        res.left_rear   = lim[2][SPEED_W-1:0];
        res.left_front  = lim[3][SPEED_W-1:0];
        return res;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch
        wheel_speeds_t             want;
        wheel_speeds_t             got;
        logic signed [SPEED_W-1:0] want_f [4];
        logic signed [SPEED_W-1:0] got_f [4];
        if (!rst_n)
        begin
            owed_speeds.delete();
            wheelbase_q = WHEELBASE_RST;
            radius_q    = RADIUS_RST;
            accel_q     = ACCEL_LIMIT_RST;
            tstep_q     = TIME_STEP_RST;
            for (int i = 0; i < 4; i++)
                held_speed[i] = '0;
            fail_count = 0;
            owed_count = 0;
        end
        else
        begin
            if (cfg.valid && cfg.ready)
            begin
                case (cfg.index)
                    REG_WHEELBASE:    wheelbase_q = cfg.data[15:0];
                    REG_RADIUS:       radius_q    = cfg.data[15:0];
                    REG_ACCEL_LIMIT:  accel_q     = cfg.data[23:0];
                    REG_TIME_STEP:    tstep_q     = cfg.data[15:0];
                    default:          ;
                endcase
            end
            if (spd.valid && spd.ready)
            begin
                got.right_rear  = spd.right_rear_speed;
                got.right_front = spd.right_front_speed;
                got.left_rear   = spd.left_rear_speed;
                got.left_front  = spd.left_front_speed;
                if (owed_speeds.size() == 0)
                begin
                    $display("%0t: unexpected speed transfer %0d %0d %0d %0d", $time,
                             got.right_rear, got.right_front, got.left_rear, got.left_front);
                    fail_count++;
                end
                else
                begin
                    want = owed_speeds.pop_front();
                    want_f = '{want.right_rear, want.right_front, want.left_rear,
                               want.left_front};
                    got_f  = '{got.right_rear, got.right_front, got.left_rear,
                               got.left_front};
                    for (int i = 0; i < 4; i++)
                    begin
                        if (got_f[i] !== want_f[i])
                        begin
                            $display("%0t: %s speed expected %0d actual %0d", $time,
                                     wheel_names[i], want_f[i], got_f[i]);
                            fail_count++;
                        end
                    end
                end
            end
            if (cmd.valid && cmd.ready)
            begin
                want = mix_and_limit(cmd.vel_x, cmd.vel_y, cmd.turn_rate);
                held_speed[0] = want.right_rear;
                held_speed[1] = want.right_front;
                held_speed[2] = want.left_rear;
                held_speed[3] = want.left_front;
                owed_speeds.push_back(want);
            end
            owed_count = owed_speeds.size();
        end
    end

endmodule

`default_nettype wire

>>> tb/sv/omni_wheel_speed_with_slew_limit_tb.sv
`default_nettype none

module omni_wheel_speed_with_slew_limit_tb
    import owsl_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    logic clk = 1'b0;
    logic rst_n;
    int   fail_count;
    int   owed_count;
    bit   no_idle = 1'b0;
    int   long_hold = 0;

    owsl_cmd_if   cmd ();
    owsl_cfg_if   cfg ();
    owsl_speed_if spd ();

    omni_wheel_speed_with_slew_limit u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd),
        .cfg   (cfg),
        .spd   (spd)
    );

    omni_wheel_speed_with_slew_limit_chk u_chk (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .cfg        (cfg),
        .spd        (spd),
        .fail_count (fail_count),
        .owed_count (owed_count)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic int draw_gap();
        return no_idle ? 0 : $urandom_range(0, 18);
    endfunction

    function automatic logic signed [VEL_W-1:0] pick_vel();
        case ($urandom_range(0, 9))
            0:       return 16'sh7FFF;
            1:       return 16'sh8000;
            2, 3:    return 16'($urandom_range(0, 511) - 256);
            default: return 16'($urandom);
        endcase
    endfunction

    // called at a falling edge, returns at the falling edge after the transfer
    task automatic send_cmd(input logic signed [VEL_W-1:0] vx, vy, w);
        int gap;
        gap = draw_gap();
        if (gap > 0)
        begin
            cmd.valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        cmd.valid     = 1'b1;
        cmd.vel_x     = vx;
        cmd.vel_y     = vy;
        cmd.turn_rate = w;
        do
            @(posedge clk);
        while (!cmd.ready);
        @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        cfg.valid = 1'b1;
        cfg.index = idx;
        cfg.data  = val;
        do
            @(posedge clk);
        while (!cfg.ready);
        @(negedge clk);
        cfg.valid = 1'b0;
    endtask

    task automatic settle();
        cmd.valid = 1'b0;
        while (owed_count != 0)
            @(negedge clk);
        repeat (8) @(negedge clk);
    endtask

    // upper byte of the 16-bit registers carries junk that must be ignored
    task automatic set_config(input logic [15:0] base, radius, input logic [23:0] accel,
                              input logic [15:0] tstep);
        settle();
        write_reg(REG_WHEELBASE, {8'($urandom), base});
        write_reg(REG_RADIUS, {8'($urandom), radius});
        write_reg(REG_ACCEL_LIMIT, accel);
        write_reg(REG_TIME_STEP, {8'($urandom), tstep});
    endtask

    initial
    begin : receiver
        int gap;
        spd.ready = 1'b0;
        wait (rst_n === 1'b1);
        @(negedge clk);
        forever
        begin
            if (long_hold > 0)
            begin
                gap       = long_hold;
                long_hold = 0;
            end
            else
                gap = draw_gap();
            if (gap > 0)
            begin
                spd.ready = 1'b0;
                repeat (gap) @(negedge clk);
            end
            spd.ready = 1'b1;
            do
                @(posedge clk);
            while (!spd.valid);
            @(negedge clk);
        end
    end

    initial
    begin : stimulus
        logic [15:0] base;
        logic [15:0] radius;
        logic [23:0] accel;
        logic [15:0] tstep;
        rst_n         = 1'b0;
        cmd.valid     = 1'b0;
        cmd.vel_x     = '0;
        cmd.vel_y     = '0;
        cmd.turn_rate = '0;
        cfg.valid     = 1'b0;
        cfg.index     = '0;
        cfg.data      = '0;
        repeat (11) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // reset settings, slew limited from rest
        send_cmd(16'sd0, 16'sd0, 16'sd0);
        send_cmd(16'sh7FFF, 16'sd0, 16'sd0);
        send_cmd(16'sh8000, 16'sd0, 16'sd0);
        send_cmd(16'sd0, 16'sh7FFF, 16'sd0);
        send_cmd(16'sd0, 16'sh8000, 16'sd0);
        send_cmd(16'sd0, 16'sd0, 16'sh7FFF);
        send_cmd(16'sd0, 16'sd0, 16'sh8000);
        send_cmd(16'sh7FFF, 16'sh7FFF, 16'sh7FFF);

        // targets beyond the speed range
        set_config(16'hFFFF, 16'd1, 24'hFFFFFF, 16'hFFFF);
        send_cmd(16'sh7FFF, 16'sh8000, 16'sh7FFF);
        send_cmd(16'sh8000, 16'sh7FFF, 16'sh8000);
        send_cmd(16'sd0, 16'sd0, 16'sh7FFF);
        send_cmd(-16'sd1, -16'sd1, -16'sd1);
        send_cmd(16'sd1, 16'sd1, 16'sd1);

        // zero radius, then zero time step with target equal and unequal
        set_config(16'd369, 16'd0, 24'hFFFFFF, 16'hFFFF);
        send_cmd(16'sd256, -16'sd256, 16'sd128);
        set_config(16'd369, 16'd0, 24'd12800, 16'd0);
        send_cmd(16'sd256, -16'sd256, 16'sd128);
        send_cmd(-16'sd256, 16'sd256, -16'sd128);
        set_config(16'd0, 16'd123, 24'd0, 16'hFFFF);
        send_cmd(16'sd1000, 16'sd2000, -16'sd3000);
        send_cmd(16'sd0, 16'sd0, 16'sd0);

        for (int p = 0; p < 8; p++)
        begin
            if (p == 0)
            begin
                base   = WHEELBASE_RST;
                radius = RADIUS_RST;
                accel  = ACCEL_LIMIT_RST;
                tstep  = TIME_STEP_RST;
            end
            else
            begin
                case ($urandom_range(0, 3))
                    0:       base = 16'd0;
                    1:       base = 16'hFFFF;
                    2:       base = 16'($urandom);
                    default: base = 16'($urandom_range(100, 1000));
                endcase
                case ($urandom_range(0, 5))
                    0:       radius = 16'd0;
                    1:       radius = 16'd1;
                    2:       radius = 16'hFFFF;
                    3:       radius = 16'($urandom);
                    default: radius = 16'($urandom_range(50, 500));
                endcase
                case ($urandom_range(0, 3))
                    0:       accel = 24'd0;
                    1:       accel = 24'hFFFFFF;
                    2:       accel = 24'($urandom);
                    default: accel = 24'($urandom_range(1000, 50000));
                endcase
                case ($urandom_range(0, 4))
                    0:       tstep = 16'd0;
                    1:       tstep = 16'd1;
                    2:       tstep = 16'hFFFF;
                    3:       tstep = 16'($urandom);
                    default: tstep = 16'($urandom_range(100, 2000));
                endcase
            end
            set_config(base, radius, accel, tstep);
            if (p == 0)
            begin
                // output side stalls while commands keep coming
                long_hold = 600;
                no_idle   = 1'b1;
            end
            no_idle = no_idle || (p == 3);
            for (int n = 0; n < 210; n++)
            begin
                if (p == 0 && n == 40)
                    no_idle = 1'b0;
                send_cmd(pick_vel(), pick_vel(), pick_vel());
            end
            no_idle = 1'b0;
        end

        settle();
        repeat (100) @(negedge clk);
        if (fail_count == 0 && owed_count == 0)
            $display("omni_wheel_speed_with_slew_limit regression: pass");
        else
            $display("omni_wheel_speed_with_slew_limit regression: fail");
        $finish;
    end

    initial
    begin
        #10_000_000;
        $display("omni_wheel_speed_with_slew_limit regression: fail");
        $finish;
    end

endmodule

`default_nettype wire
